// ----- sv/pfla_pkg.sv -----
// ----------------------------------------------------------------------------
// pfla_pkg
// Shared types, codes and defaults of the page free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfla_pkg;

  localparam int NUM_PAGES_DEF  = 256;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam int ADDR_W   = 64;
  localparam int STATUS_W = 3;

  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam status_t STAT_OK        = 3'd0;
  localparam status_t STAT_TOO_LARGE = 3'd1;
  localparam status_t STAT_NO_PAGE   = 3'd2;
  localparam status_t STAT_BELOW     = 3'd3;
  localparam status_t STAT_EXTERNAL  = 3'd4;
  localparam status_t STAT_NULL      = 3'd5;

endpackage

`default_nettype wire

// ----- sv/pfla_if.sv -----
// ----------------------------------------------------------------------------
// pfla_if
// Request and response channels of the page free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfla_req_if
  import pfla_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  mode;
  addr_t request_size;
  addr_t free_address;

  modport source (output valid, output mode, output request_size, output free_address,
                  input ready);
  modport sink   (input valid, input mode, input request_size, input free_address,
                  output ready);
endinterface

interface pfla_rsp_if
  import pfla_pkg::*;
();
  logic    valid;
  logic    ready;
  addr_t   page_address;
  status_t status;

  modport source (output valid, output page_address, output status, input ready);
  modport sink   (input valid, input page_address, input status, output ready);
endinterface

`default_nettype wire

// ----- sv/pfla_link_ram.sv -----
// ----------------------------------------------------------------------------
// pfla_link_ram
// Link memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfla_link_ram
  import pfla_pkg::*;
#(
  parameter int DEPTH = NUM_PAGES_DEF + 2,
  parameter int WIDTH = $clog2(NUM_PAGES_DEF + 2)
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/pfla_index_div.sv -----
// ----------------------------------------------------------------------------
// pfla_index_div
// Page index of a pool offset by reciprocal multiplication, with a registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module pfla_index_div
  import pfla_pkg::*;
#(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        start,
  input  wire logic [$clog2(NUM_PAGES*PAGE_BYTES)-1:0]     offset,
  output logic                                             done,
  output logic      [$clog2(NUM_PAGES)-1:0]                quot
);

  localparam int OFF_W  = $clog2(NUM_PAGES * PAGE_BYTES);
  localparam int PG_W   = $clog2(NUM_PAGES);
  localparam int SH     = OFF_W + $clog2(PAGE_BYTES);
  localparam int RCP_W  = OFF_W + 1;
  localparam int PROD_W = OFF_W + RCP_W;
  localparam longint unsigned RCP_L =
    ((64'd1 << SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_L);

  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
    if (start) begin
      prod <= PROD_W'(offset) * PROD_W'(RCP);
    end
  end

  assign quot = prod[SH +: PG_W];

endmodule

`default_nettype wire

// ----- sv/page_free_list_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// page_free_list_allocator_unit
// Fixed pool of equal pages kept on doubly linked free and used lists.
// ----------------------------------------------------------------------------
// After reset a clearing pass over all NUM_PAGES+2 link entries writes
// the link memories with every page free in index order; req.ready stays
// low meanwhile. One request is worked at a time. A successful allocate or
// free raises rsp.valid after these steps in order: a check, a free-head
// read (allocate) or a page index multiply (free), the read-modify-write
// of the link memories (unlink, then append) and the move of the result
// into the output register, which waits while the last word is unaccepted.
// Errors found at the check and an empty pool found after the free-head
// read skip to that move. req.ready rises once the result has moved into
// the output register, so a new request is taken only after the last one
// is done. The result register lets a new request be accepted while the
// last word waits. Errors are flagged in status and leave the lists unchanged.
`default_nettype none

module page_free_list_allocator_unit
  import pfla_pkg::*;
#(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire addr_t       cfg_wr_data,
  pfla_req_if.sink         req,
  pfla_rsp_if.source       rsp
);

  localparam int NODE_CNT = NUM_PAGES + 2;
  localparam int NODE_W   = $clog2(NODE_CNT);
  localparam int PG_W     = $clog2(NUM_PAGES);
  localparam int OFF_W    = $clog2(NUM_PAGES * PAGE_BYTES);
  localparam int PB_W     = $clog2(PAGE_BYTES + 1);
  localparam int PROD_W   = NODE_W + PB_W;

  localparam logic [NODE_W-1:0] FREE_HEAD = NODE_W'(NUM_PAGES);
  localparam logic [NODE_W-1:0] USED_HEAD = NODE_W'(NUM_PAGES + 1);
  localparam logic [NODE_W-1:0] LAST_PAGE = NODE_W'(NUM_PAGES - 1);
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_CNT - 1);
  localparam addr_t POOL_BYTES = 64'(NUM_PAGES) * 64'(PAGE_BYTES);
  localparam addr_t PAGE_LIMIT = 64'(PAGE_BYTES);

  localparam int SW = 3;
  localparam logic [SW-1:0] S_INIT = 3'd0;
  localparam logic [SW-1:0] S_IDLE = 3'd1;
  localparam logic [SW-1:0] S_CHK  = 3'd2;
  localparam logic [SW-1:0] S_HEAD = 3'd3;
  localparam logic [SW-1:0] S_DIV  = 3'd4;
  localparam logic [SW-1:0] S_UNL  = 3'd5;
  localparam logic [SW-1:0] S_APA  = 3'd6;
  localparam logic [SW-1:0] S_APB  = 3'd7;

  logic [SW-1:0]     state;
  logic              done_pend;
  logic [NODE_W-1:0] init_idx;
  addr_t             base;
  logic              mode_r;
  addr_t             size_r;
  addr_t             addr_r;
  logic [NODE_W-1:0] node;
  logic [NODE_W-1:0] head;
  logic [NODE_W-1:0] p_r;
  logic              q_is_h;
  logic [PROD_W-1:0] prod;
  status_t           res_status;
  logic              res_addr_en;
  logic              out_valid;
  addr_t             out_addr;
  status_t           out_status;

  logic              below;
  addr_t             off;
  logic              external;
  logic              too_large;
  logic [NODE_W-1:0] tail;
  logic [NODE_W-1:0] init_next;
  logic [NODE_W-1:0] init_prev;

  logic              next_we;
  logic [NODE_W-1:0] next_waddr;
  logic [NODE_W-1:0] next_wdata;
  logic [NODE_W-1:0] next_raddr;
  logic [NODE_W-1:0] next_rdata;
  logic              prev_we;
  logic [NODE_W-1:0] prev_waddr;
  logic [NODE_W-1:0] prev_wdata;
  logic [NODE_W-1:0] prev_raddr;
  logic [NODE_W-1:0] prev_rdata;

  logic              div_start;
  logic              div_done;
  logic [PG_W-1:0]   div_quot;

  pfla_link_ram #(.DEPTH(NODE_CNT), .WIDTH(NODE_W)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (next_raddr),
    .rdata (next_rdata)
  );

  pfla_link_ram #(.DEPTH(NODE_CNT), .WIDTH(NODE_W)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (prev_raddr),
    .rdata (prev_rdata)
  );

  pfla_index_div #(.NUM_PAGES(NUM_PAGES), .PAGE_BYTES(PAGE_BYTES)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .offset (off[OFF_W-1:0]),
    .done   (div_done),
    .quot   (div_quot)
  );

  always_comb begin
    {below, off} = {1'b0, addr_r} - {1'b0, base};
    external     = off >= POOL_BYTES;
    too_large    = size_r > PAGE_LIMIT;
    tail         = q_is_h ? p_r : prev_rdata;

    if (init_idx == FREE_HEAD) begin
      init_next = '0;
      init_prev = LAST_PAGE;
    end else if (init_idx == USED_HEAD) begin
      init_next = USED_HEAD;
      init_prev = USED_HEAD;
    end else begin
      init_next = (init_idx == LAST_PAGE) ? FREE_HEAD : init_idx + NODE_W'(1);
      init_prev = (init_idx == '0) ? FREE_HEAD : init_idx - NODE_W'(1);
    end

    next_we    = 1'b0;
    next_waddr = '0;
    next_wdata = '0;
    next_raddr = '0;
    prev_we    = 1'b0;
    prev_waddr = '0;
    prev_wdata = '0;
    prev_raddr = '0;

    case (state)
      S_INIT: begin
        next_we    = 1'b1;
        next_waddr = init_idx;
        next_wdata = init_next;
        prev_we    = 1'b1;
        prev_waddr = init_idx;
        prev_wdata = init_prev;
      end
      S_CHK: begin
        next_raddr = FREE_HEAD;
      end
      S_HEAD: begin
        next_raddr = next_rdata;
        prev_raddr = next_rdata;
      end
      S_DIV: begin
        next_raddr = NODE_W'(div_quot);
        prev_raddr = NODE_W'(div_quot);
      end
      S_UNL: begin
        next_we    = 1'b1;
        next_waddr = prev_rdata;
        next_wdata = next_rdata;
        prev_we    = 1'b1;
        prev_waddr = next_rdata;
        prev_wdata = prev_rdata;
        prev_raddr = head;
      end
      S_APA: begin
        next_we    = 1'b1;
        next_waddr = tail;
        next_wdata = node;
        prev_we    = 1'b1;
        prev_waddr = node;
        prev_wdata = tail;
      end
      S_APB: begin
        next_we    = 1'b1;
        next_waddr = node;
        next_wdata = head;
        prev_we    = 1'b1;
        prev_waddr = head;
        prev_wdata = node;
      end
      default: begin
      end
    endcase
  end

  assign div_start = (state == S_CHK) && (mode_r == MODE_FREE) && (addr_r != '0) &&
                     !below && !external;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      done_pend <= 1'b0;
      init_idx  <= '0;
      base      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base <= cfg_wr_data;
      end
      if (done_pend && (!out_valid || rsp.ready)) begin
        done_pend  <= 1'b0;
        out_valid  <= 1'b1;
        out_addr   <= res_addr_en ? base + 64'(prod) : '0;
        out_status <= res_status;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          init_idx <= init_idx + NODE_W'(1);
          if (init_idx == LAST_NODE) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            mode_r <= req.mode;
            size_r <= req.request_size;
            addr_r <= req.free_address;
            state  <= S_CHK;
          end
        end
        S_CHK: begin
          res_addr_en <= 1'b0;
          if (mode_r == MODE_ALLOC) begin
            if (too_large) begin
              res_status <= STAT_TOO_LARGE;
              done_pend  <= 1'b1;
              state      <= S_IDLE;
            end else begin
              res_status <= STAT_OK;
              state      <= S_HEAD;
            end
          end else if (addr_r == '0) begin
            res_status <= STAT_NULL;
            done_pend  <= 1'b1;
            state      <= S_IDLE;
          end else if (below) begin
            res_status <= STAT_BELOW;
            done_pend  <= 1'b1;
            state      <= S_IDLE;
          end else if (external) begin
            res_status <= STAT_EXTERNAL;
            done_pend  <= 1'b1;
            state      <= S_IDLE;
          end else begin
            res_status <= STAT_OK;
            state      <= S_DIV;
          end
        end
        S_HEAD: begin
          if (next_rdata == FREE_HEAD) begin
            res_status <= STAT_NO_PAGE;
            done_pend  <= 1'b1;
            state      <= S_IDLE;
          end else begin
            node        <= next_rdata;
            head        <= USED_HEAD;
            res_addr_en <= 1'b1;
            state       <= S_UNL;
          end
        end
        S_DIV: begin
          if (div_done) begin
            node  <= NODE_W'(div_quot);
            head  <= FREE_HEAD;
            state <= S_UNL;
          end
        end
        S_UNL: begin
          p_r    <= prev_rdata;
          q_is_h <= next_rdata == head;
          state  <= S_APA;
        end
        S_APA: begin
          state <= S_APB;
        end
        S_APB: begin
          prod      <= PROD_W'(node) * PROD_W'(PAGE_BYTES);
          done_pend <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE) && !done_pend;
  assign rsp.valid        = out_valid;
  assign rsp.page_address = out_addr;
  assign rsp.status       = out_status;

  a_unlink_page: assert property (@(posedge clk) disable iff (rst)
    (state == S_UNL) |-> (node != FREE_HEAD) && (node != USED_HEAD))
    else $error("list head taken as a page to move");

  a_tail_not_node: assert property (@(posedge clk) disable iff (rst)
    (state == S_APA) |-> (tail != node))
    else $error("append tail equals the moved page");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the index wait");

  a_error_no_addr: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != STAT_OK)) |-> (rsp.page_address == '0))
    else $error("error word carries a page address");

endmodule

`default_nettype wire
